// ===== rtl/qprq_pkg.sv =====
// Shared constants, codes, types and helpers for the QoS-1 publish retransmit queue.
// No dependencies; imported by the interfaces and every module of the block.
package qprq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

   // Result buffer geometry (power of two)
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W = $clog2(RSP_DEPTH + 1);

   // Field widths
   localparam int CMD_W    = 2;
   localparam int HANDLE_W = 16;
   localparam int PID_W    = 16;
   localparam int QOS_W    = 2;
   localparam int EV_W     = 3;
   localparam int PERIOD_W = 16;
   localparam int COUNT_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Commands
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

   // Result events
   localparam logic [EV_W-1:0] EV_SEND      = 3'd0;
   localparam logic [EV_W-1:0] EV_ACKED     = 3'd1;
   localparam logic [EV_W-1:0] EV_RETRY     = 3'd2;
   localparam logic [EV_W-1:0] EV_MALFORMED = 3'd3;
   localparam logic [EV_W-1:0] EV_OVERWRITE = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RETRY_LIMIT = 2'd1;

   // Reset values and limits
   localparam logic [PERIOD_W-1:0] TICK_PERIOD_RESET = 16'd500;
   localparam logic [COUNT_W-1:0]  RETRY_LIMIT_RESET = 6'd20;
   localparam logic [COUNT_W-1:0]  COUNT_MAX         = 6'd63;
   localparam logic [QOS_W-1:0]    QOS_GOOD          = 2'd1;

   // One input item
   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [HANDLE_W-1:0] payload_handle;
      logic [PID_W-1:0]    packet_id;
      logic [QOS_W-1:0]    qos_level;
      logic                topic_present;
      logic                payload_present;
      logic                link_up;
   } req_type;

   // One result item
   typedef struct packed {
      logic [EV_W-1:0]     event_res;
      logic [HANDLE_W-1:0] handle_out;
      logic [PID_W-1:0]    packet_id_out;
      logic                last;
   } rsp_type;

   // One stored descriptor; flags bit 0 topic, bit 1 payload
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [PID_W-1:0]    packet_id;
      logic [QOS_W-1:0]    qos;
      logic [1:0]          flags;
      logic [COUNT_W-1:0]  send_count;
   } slot_type;

   // Core to store control
   typedef struct packed {
      logic               push;
      logic               pop;
      logic               count_wr;
      logic [COUNT_W-1:0] count_val;
      slot_type           wdata;
   } store_ctrl_type;

   // Core to result buffer; valid1 only together with valid0
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rsp_type item0;
      rsp_type item1;
   } rsp_push_type;

   // Ring index advance
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + IDX_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/qprq_if.sv =====
// Handshake channel interfaces: request, result and register write.
// Depends on qprq_pkg for field widths.
interface qprq_req_if import qprq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [HANDLE_W-1:0] payload_handle;
   logic [PID_W-1:0]    packet_id;
   logic [QOS_W-1:0]    qos_level;
   logic                topic_present;
   logic                payload_present;
   logic                link_up;

   modport source (output valid, command, payload_handle, packet_id, qos_level,
                   topic_present, payload_present, link_up, input ready);
   modport sink   (input valid, command, payload_handle, packet_id, qos_level,
                   topic_present, payload_present, link_up, output ready);
endinterface

interface qprq_rsp_if import qprq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [EV_W-1:0]     event_res;
   logic [HANDLE_W-1:0] handle_out;
   logic [PID_W-1:0]    packet_id_out;
   logic                last;

   modport source (output valid, event_res, handle_out, packet_id_out, last,
                   input ready);
   modport sink   (input valid, event_res, handle_out, packet_id_out, last,
                   output ready);
endinterface

interface qprq_csr_if import qprq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/qprq_store.sv =====
// Descriptor ring: slot storage, head and tail pointers, occupancy.
// Depends on qprq_pkg; driven by qprq_core through store_ctrl_type.
module qprq_store import qprq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  store_ctrl_type ctrl,
   output slot_type       head_slot,
   output logic [OCC_W-1:0] occupancy
);

   slot_type         slots_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   // Pointer and fill update; eviction pops and pushes in one go
   always_comb begin
      head_in = ctrl.pop  ? next_idx(head_ff) : head_ff;
      tail_in = ctrl.push ? next_idx(tail_ff) : tail_ff;
      occ_in  = occ_ff + OCC_W'(ctrl.push) - OCC_W'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // Slot writes: new descriptor at tail, send count at head
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         slots_ff[tail_ff] <= ctrl.wdata;
      end
      if (ctrl.count_wr) begin
         slots_ff[head_ff].send_count <= ctrl.count_val;
      end
   end

   assign head_slot = slots_ff[head_ff];
   assign occupancy = occ_ff;

endmodule

// ===== rtl/qprq_rsp_buf.sv =====
// Result buffer: small ring taking up to two items a cycle, draining one while out_ready is high.
// Depends on qprq_pkg; feeds the result channel of the top level.
module qprq_rsp_buf import qprq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  rsp_push_type   push,
   input  logic           out_ready,
   output logic           out_valid,
   output rsp_type        out_item,
   output logic [RSP_LVL_W-1:0] level
);

   rsp_type              buf_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ff, wr_in;
   logic [RSP_PTR_W-1:0] rd_ff, rd_in;
   logic [RSP_LVL_W-1:0] lvl_ff, lvl_in;
   logic [1:0]           push_n;
   logic                 pop;

   // Pointer and level update
   always_comb begin
      push_n = 2'(push.valid0) + 2'(push.valid1);
      pop    = out_valid && out_ready;
      wr_in  = wr_ff + RSP_PTR_W'(push_n);
      rd_in  = rd_ff + RSP_PTR_W'(pop);
      lvl_in = lvl_ff + RSP_LVL_W'(push_n) - RSP_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         lvl_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         lvl_ff <= lvl_in;
      end
   end

   // Entry writes
   always_ff @(posedge clock) begin
      if (push.valid0) begin
         buf_ff[wr_ff] <= push.item0;
      end
      if (push.valid1) begin
         buf_ff[wr_ff + RSP_PTR_W'(1)] <= push.item1;
      end
   end

   assign out_valid = (lvl_ff != '0);
   assign out_item  = buf_ff[rd_ff];
   assign level     = lvl_ff;

endmodule

// ===== rtl/qprq_core.sv =====
// Command processing: enqueue/evict, ack capture, tick divider and head check.
// Depends on qprq_pkg; drives qprq_store and qprq_rsp_buf.
module qprq_core import qprq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  req_type             item,
   input  slot_type            head_slot,
   input  logic [OCC_W-1:0]    occupancy,
   input  logic [PERIOD_W-1:0] tick_period,
   input  logic [COUNT_W-1:0]  retry_limit,
   output store_ctrl_type      store_ctrl,
   output rsp_push_type        rsp_push
);

   logic [PERIOD_W-1:0] tick_ff, tick_in;
   logic [PID_W-1:0]    ack_ff, ack_in;
   logic                full;
   logic                empty;
   logic [COUNT_W-1:0]  new_count;
   logic                malformed;
   logic                freeing;
   rsp_type             head_rsp;
   rsp_type             free_rsp;

   assign full  = (occupancy == OCC_W'(QUEUE_DEPTH));
   assign empty = (occupancy == '0);

   // Head check terms
   always_comb begin
      new_count = head_slot.send_count;
      if (item.link_up && (head_slot.send_count != COUNT_MAX)) begin
         new_count = head_slot.send_count + COUNT_W'(1);
      end
      malformed = (head_slot.qos != QOS_GOOD) || !head_slot.flags[0] ||
                  !head_slot.flags[1];
      freeing   = (new_count > retry_limit) || malformed;

      head_rsp.event_res     = EV_SEND;
      head_rsp.handle_out    = head_slot.handle;
      head_rsp.packet_id_out = head_slot.packet_id;
      head_rsp.last          = 1'b1;

      free_rsp = head_rsp;
      free_rsp.event_res = (malformed && (new_count <= retry_limit)) ?
                           EV_MALFORMED : EV_RETRY;
   end

   // Command decode
   always_comb begin
      store_ctrl = '0;
      rsp_push   = '0;
      tick_in    = tick_ff;
      ack_in     = ack_ff;

      store_ctrl.count_val               = new_count;
      store_ctrl.wdata.handle            = item.payload_handle;
      store_ctrl.wdata.packet_id         = item.packet_id;
      store_ctrl.wdata.qos               = item.qos_level;
      store_ctrl.wdata.flags             = {item.payload_present, item.topic_present};
      store_ctrl.wdata.send_count        = '0;
      rsp_push.item0 = head_rsp;
      rsp_push.item1 = free_rsp;

      if (fire) begin
         unique case (item.command)
            CMD_ENQUEUE: begin
               // evict the oldest descriptor when full
               store_ctrl.push = 1'b1;
               if (full) begin
                  store_ctrl.pop           = 1'b1;
                  rsp_push.valid0          = 1'b1;
                  rsp_push.item0.event_res = EV_OVERWRITE;
               end
            end
            CMD_ACK: begin
               ack_in = item.packet_id;
            end
            CMD_TICK: begin
               if (tick_ff < tick_period) begin
                  tick_in = tick_ff + PERIOD_W'(1);
               end else begin
                  tick_in = '0;
                  if (!empty) begin
                     if (head_slot.packet_id == ack_ff) begin
                        store_ctrl.pop           = 1'b1;
                        rsp_push.valid0          = 1'b1;
                        rsp_push.item0.event_res = EV_ACKED;
                     end else if (item.link_up) begin
                        // send, then maybe free as second result
                        store_ctrl.count_wr = 1'b1;
                        rsp_push.valid0     = 1'b1;
                        rsp_push.item0.last = !freeing;
                        rsp_push.valid1     = freeing;
                        store_ctrl.pop      = freeing;
                     end else if (freeing) begin
                        store_ctrl.pop  = 1'b1;
                        rsp_push.valid0 = 1'b1;
                        rsp_push.item0  = free_rsp;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         ack_ff  <= '0;
      end else begin
         tick_ff <= tick_in;
         ack_ff  <= ack_in;
      end
   end

endmodule

// ===== rtl/qos1_publish_retransmit_queue.sv =====
// QoS-1 publish retransmit queue, top level. An accepted item is held in the input
// register and processed from there once the result buffer has room; its results
// go through the four-entry result buffer to rsp_chan. Throughput: one item per
// cycle while that buffer has room for two results; results leave at one per
// cycle while rsp_chan.ready is high. Synchronous reset clears pointers, counters
// and the last ack id and loads tick_period 500, retry_limit 20.
module qos1_publish_retransmit_queue import qprq_pkg::*; (
   input logic        clock,
   input logic        reset,
   qprq_req_if.sink   req_chan,
   qprq_rsp_if.source rsp_chan,
   qprq_csr_if.sink   csr_chan
);

   req_type                in_ff;
   logic                   in_valid_ff, in_valid_in;
   logic [PERIOD_W-1:0]    period_ff;
   logic [COUNT_W-1:0]     retry_ff;
   logic                   fire;
   logic                   accept;
   logic [RSP_LVL_W-1:0]   rsp_level;
   logic [OCC_W-1:0]       occupancy;
   slot_type               head_slot;
   store_ctrl_type         store_ctrl;
   rsp_push_type           rsp_push;
   rsp_type                out_item;

   // Input register; process when the result buffer can take two items
   assign fire           = in_valid_ff && (rsp_level <= RSP_LVL_W'(RSP_DEPTH - 2));
   assign req_chan.ready = !in_valid_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.command         <= req_chan.command;
         in_ff.payload_handle  <= req_chan.payload_handle;
         in_ff.packet_id       <= req_chan.packet_id;
         in_ff.qos_level       <= req_chan.qos_level;
         in_ff.topic_present   <= req_chan.topic_present;
         in_ff.payload_present <= req_chan.payload_present;
         in_ff.link_up         <= req_chan.link_up;
      end
   end

   // Configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= TICK_PERIOD_RESET;
         retry_ff  <= RETRY_LIMIT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_TICK_PERIOD: period_ff <= csr_chan.data[PERIOD_W-1:0];
            REG_RETRY_LIMIT: retry_ff  <= csr_chan.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   qprq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_ff),
      .head_slot   (head_slot),
      .occupancy   (occupancy),
      .tick_period (period_ff),
      .retry_limit (retry_ff),
      .store_ctrl  (store_ctrl),
      .rsp_push    (rsp_push)
   );

   qprq_store u_store (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (store_ctrl),
      .head_slot (head_slot),
      .occupancy (occupancy)
   );

   qprq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_item  (out_item),
      .level     (rsp_level)
   );

   assign rsp_chan.event_res     = out_item.event_res;
   assign rsp_chan.handle_out    = out_item.handle_out;
   assign rsp_chan.packet_id_out = out_item.packet_id_out;
   assign rsp_chan.last          = out_item.last;

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(QUEUE_DEPTH))
      else $error("descriptor ring overfilled");

   a_rsp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_level <= RSP_LVL_W'(RSP_DEPTH))
      else $error("result buffer overfilled");

   a_evict: assert property (@(posedge clock) disable iff (reset)
      fire && (in_ff.command == CMD_ENQUEUE) && (occupancy == OCC_W'(QUEUE_DEPTH))
      |-> rsp_push.valid0 && (rsp_push.item0.event_res == EV_OVERWRITE))
      else $error("full enqueue without eviction result");

   a_ack_silent: assert property (@(posedge clock) disable iff (reset)
      fire && (in_ff.command == CMD_ACK) |-> !rsp_push.valid0 && !store_ctrl.pop)
      else $error("ack touched the queue");

   a_pop_push: assert property (@(posedge clock) disable iff (reset)
      store_ctrl.pop |=> occupancy == $past(occupancy) - OCC_W'(1) +
                                      OCC_W'($past(store_ctrl.push)))
      else $error("occupancy out of step with pops");

endmodule
